// ----- rtl/rgb_breathing_fade_sequencer_macros.svh -----
// assertion macros shared by the breathing sequencer rtl
`ifndef RGB_BREATHING_FADE_SEQUENCER_MACROS_SVH
`define RGB_BREATHING_FADE_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RBFS_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RBFS_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rbfs_pkg.sv -----
package rbfs_pkg;

  localparam int LEVEL_W    = 8;
  localparam int TOTAL_W    = 16;
  localparam int NOW_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 2;
  localparam int DIV_CNT_W  = $clog2(TOTAL_W);

  // breathing phase, also the value of the phase output
  typedef enum logic [1:0] {
    PH_RISE,
    PH_HOLD_ON,
    PH_FALL,
    PH_HOLD_OFF
  } phase_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CMP,
    ST_FINISH,
    ST_OUT
  } state_t;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TIME     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_TIME     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_ON_TIME  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_OFF_TIME = 3'd6;

  // divider request and response
  typedef struct packed {
    logic                 start;
    logic [TOTAL_W-1:0]   dividend;
    logic [LEVEL_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [TOTAL_W-1:0]   quotient;
  } div_rsp_t;

endpackage

// ----- rtl/rbfs_div.sv -----
module rbfs_div (
  input  logic              clk,
  input  logic              rst,
  input  rbfs_pkg::div_req_t req,
  output rbfs_pkg::div_rsp_t rsp
);
  import rbfs_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [LEVEL_W-1:0]   rem;
  logic [TOTAL_W-1:0]   dq;
  logic [LEVEL_W-1:0]   dvs;
  logic [LEVEL_W:0]     trial;
  logic [LEVEL_W:0]     diff;
  logic                 fits;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign trial = {rem, dq[TOTAL_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(TOTAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dq  <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
      dq  <= {dq[TOTAL_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

// ----- rtl/rgb_breathing_fade_sequencer.sv -----
// rgb breathing fade sequencer
// in channel: in_valid/in_ready carry one time beat (now). out channel:
// out_valid/out_ready carry the levels and phase after that beat, one result
// per input beat. config: cfg_we/cfg_index/cfg_data write a register; the user
// must write only while the block is idle, the block does not enforce it.
// the block works on one beat at a time and drops in_ready while busy.
// in the rising and falling phases each of the three channels runs its step
// interval (time / target) through one shared serial divider and then one
// shared subtract-and-compare; hold phases skip the divider.
// the output register frees the datapath: a new beat is taken while the last
// result still waits; if the receiver stalls, the next result waits in the
// sequencer until the output register empties.
// reset (rst, synchronous) clears registers, levels, stamps and out_valid,
// and starts in the rising phase.
module rgb_breathing_fade_sequencer #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rbfs_pkg::NOW_W-1:0]       now,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rbfs_pkg::LEVEL_W-1:0]     level_red,
  output logic [rbfs_pkg::LEVEL_W-1:0]     level_green,
  output logic [rbfs_pkg::LEVEL_W-1:0]     level_blue,
  output logic [1:0]                       phase,
  input  logic                             cfg_we,
  input  logic [rbfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rbfs_pkg::*;

`include "rgb_breathing_fade_sequencer_macros.svh"

  // config registers
  logic [LEVEL_W-1:0] target [NUM_CH];
  logic [TOTAL_W-1:0] rise_time;
  logic [TOTAL_W-1:0] fall_time;
  logic [TOTAL_W-1:0] hold_on_time;
  logic [TOTAL_W-1:0] hold_off_time;

  // breathing state
  state_t              state;
  state_t              state_next;
  phase_t              breath_phase;
  phase_t              out_phase;
  logic [LEVEL_W-1:0]  level [NUM_CH];
  logic [TIME_WIDTH-1:0] rise_stamp [NUM_CH];
  logic [TIME_WIDTH-1:0] fall_stamp [NUM_CH];
  logic [TIME_WIDTH-1:0] hold_on_stamp;
  logic [TIME_WIDTH-1:0] hold_off_stamp;
  logic [TIME_WIDTH-1:0] now_r;
  logic [CH_W-1:0]       ch;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [TIME_WIDTH-1:0] stamp_sel;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [TOTAL_W-1:0]    limit_sel;
  logic [TOTAL_W-1:0]    interval;
  logic                  passed;
  logic                  all_reached;
  logic                  all_zero;
  logic                  out_free;

  rbfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) target[i] <= '0;
      rise_time     <= '0;
      fall_time     <= '0;
      hold_on_time  <= '0;
      hold_off_time <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_RED:    target[0]     <= cfg_data[LEVEL_W-1:0];
        REG_TARGET_GREEN:  target[1]     <= cfg_data[LEVEL_W-1:0];
        REG_TARGET_BLUE:   target[2]     <= cfg_data[LEVEL_W-1:0];
        REG_RISE_TIME:     rise_time     <= cfg_data[TOTAL_W-1:0];
        REG_FALL_TIME:     fall_time     <= cfg_data[TOTAL_W-1:0];
        REG_HOLD_ON_TIME:  hold_on_time  <= cfg_data[TOTAL_W-1:0];
        REG_HOLD_OFF_TIME: hold_off_time <= cfg_data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // shared elapsed-time subtract and compare
  assign interval = (target[ch] == '0) ? '0 : div_rsp.quotient;

  always_comb begin
    case (breath_phase)
      PH_RISE:     stamp_sel = rise_stamp[ch];
      PH_FALL:     stamp_sel = fall_stamp[ch];
      PH_HOLD_ON:  stamp_sel = hold_on_stamp;
      default:     stamp_sel = hold_off_stamp;
    endcase
    case (breath_phase)
      PH_HOLD_ON:  limit_sel = hold_on_time;
      PH_HOLD_OFF: limit_sel = hold_off_time;
      default:     limit_sel = interval;
    endcase
  end

  assign elapsed = now_r - stamp_sel;
  assign passed  = (elapsed > TIME_WIDTH'(limit_sel));

  // end-of-ramp checks
  always_comb begin
    all_reached = 1'b1;
    all_zero    = 1'b1;
    for (int i = 0; i < NUM_CH; i++) begin
      if (level[i] < target[i]) all_reached = 1'b0;
      if (level[i] != '0) all_zero = 1'b0;
    end
  end

  assign out_free = !out_valid || out_ready;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and divider request
  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = (breath_phase == PH_RISE) ? rise_time : fall_time;
    div_req.divisor  = target[ch];
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (breath_phase == PH_RISE || breath_phase == PH_FALL) begin
            state_next = ST_DIV_START;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = (ch == '0) ? ST_FINISH : ST_DIV_START;
      end
      ST_FINISH: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // breathing datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      breath_phase   <= PH_RISE;
      hold_on_stamp  <= '0;
      hold_off_stamp <= '0;
      ch             <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        level[i]      <= '0;
        rise_stamp[i] <= '0;
        fall_stamp[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            now_r <= TIME_WIDTH'(now);
            ch    <= CH_W'(NUM_CH - 1);
          end
        end
        ST_CMP: begin
          // per-channel step when its interval has passed
          if (passed) begin
            if (breath_phase == PH_RISE) begin
              rise_stamp[ch] <= now_r;
              if (level[ch] < target[ch]) level[ch] <= level[ch] + 1'b1;
            end else begin
              fall_stamp[ch] <= now_r;
              if (level[ch] != '0) level[ch] <= level[ch] - 1'b1;
            end
          end
          if (ch != '0) ch <= ch - 1'b1;
        end
        ST_FINISH: begin
          case (breath_phase)
            PH_RISE: begin
              if (all_reached) breath_phase <= PH_HOLD_ON;
            end
            PH_FALL: begin
              if (all_zero) breath_phase <= PH_HOLD_OFF;
            end
            PH_HOLD_ON: begin
              if (hold_on_stamp == '0) begin
                hold_on_stamp <= now_r;
              end else if (passed) begin
                hold_on_stamp <= '0;
                breath_phase  <= PH_FALL;
              end
            end
            default: begin
              for (int i = 0; i < NUM_CH; i++) level[i] <= '0;
              if (hold_off_stamp == '0) begin
                hold_off_stamp <= now_r;
              end else if (passed) begin
                hold_off_stamp <= '0;
                breath_phase   <= PH_RISE;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid   <= 1'b1;
        level_red   <= level[0];
        level_green <= level[1];
        level_blue  <= level[2];
        out_phase   <= breath_phase;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign phase = out_phase;

  `RBFS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready,
    "input taken again while a beat is in work")
  `RBFS_ASSERT_NOW(a_div_done_in_wait, clk, rst, div_rsp.done, state == ST_DIV_WAIT,
    "divider finished outside the wait state")
  `RBFS_ASSERT_NOW(a_hold_off_dark, clk, rst, out_valid && out_phase == PH_HOLD_OFF,
    level_red == '0 && level_green == '0 && level_blue == '0,
    "hold-off result carries a lit level")

endmodule

// ----- tb/rgb_breathing_fade_checker.sv -----
module rgb_breathing_fade_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [rbfs_pkg::NOW_W-1:0]       now,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [rbfs_pkg::LEVEL_W-1:0]     level_red,
  input  logic [rbfs_pkg::LEVEL_W-1:0]     level_green,
  input  logic [rbfs_pkg::LEVEL_W-1:0]     level_blue,
  input  logic [1:0]                       phase,
  input  logic                             cfg_we,
  input  logic [rbfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               error_count,
  output int                               results_owed
);
  import rbfs_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    phase_t             ph;
  } glow_beat_t;

  // shadow copy of the config registers
  logic [LEVEL_W-1:0] peak [NUM_CH];
  logic [TOTAL_W-1:0] rise_span;
  logic [TOTAL_W-1:0] fall_span;
  logic [TOTAL_W-1:0] hold_on_span;
  logic [TOTAL_W-1:0] hold_off_span;

  // predicted breathing state
  phase_t             breath;
  logic [LEVEL_W-1:0] glow [NUM_CH];
  logic [NOW_W-1:0]   rise_mark [NUM_CH];
  logic [NOW_W-1:0]   fall_mark [NUM_CH];
  logic [NOW_W-1:0]   hold_on_mark;
  logic [NOW_W-1:0]   hold_off_mark;

  glow_beat_t glow_due [$];
  glow_beat_t want;
  glow_beat_t seen;

  // ticks between single steps; a zero peak gives no wait at all
  function automatic logic [TOTAL_W-1:0] step_wait(input logic [TOTAL_W-1:0] total,
                                                   input logic [LEVEL_W-1:0] top);
    if (top == '0) return '0;
    return total / top;
  endfunction

  // advance the breathing cycle by one time beat and queue the levels it shows
  task automatic breathe(input logic [NOW_W-1:0] t);
    logic [NOW_W-1:0] waited;
    logic             settled;
    glow_beat_t       next_beat;
    case (breath)
      PH_RISE: begin
        for (int c = 0; c < NUM_CH; c++) begin
          waited = t - rise_mark[c];
          if (waited > step_wait(rise_span, peak[c])) begin
            rise_mark[c] = t;
            if (glow[c] < peak[c]) glow[c] = glow[c] + 1'b1;
          end
        end
        settled = 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
          if (glow[c] < peak[c]) settled = 1'b0;
        end
        if (settled) breath = PH_HOLD_ON;
      end
      PH_HOLD_ON: begin
        waited = t - hold_on_mark;
        if (hold_on_mark == '0) begin
          hold_on_mark = t;
        end else if (waited > hold_on_span) begin
          hold_on_mark = '0;
          breath = PH_FALL;
        end
      end
      PH_FALL: begin
        for (int c = 0; c < NUM_CH; c++) begin
          waited = t - fall_mark[c];
          if (waited > step_wait(fall_span, peak[c])) begin
            fall_mark[c] = t;
            if (glow[c] != '0) glow[c] = glow[c] - 1'b1;
          end
        end
        if (glow[0] == '0 && glow[1] == '0 && glow[2] == '0) breath = PH_HOLD_OFF;
      end
      default: begin
        // dark hold forces every channel off
        for (int c = 0; c < NUM_CH; c++) glow[c] = '0;
        waited = t - hold_off_mark;
        if (hold_off_mark == '0) begin
          hold_off_mark = t;
        end else if (waited > hold_off_span) begin
          hold_off_mark = '0;
          breath = PH_RISE;
        end
      end
    endcase
    next_beat.red   = glow[0];
    next_beat.green = glow[1];
    next_beat.blue  = glow[2];
    next_beat.ph    = breath;
    glow_due.push_back(next_beat);
  endtask

  task automatic report_field(input string label, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t: %s expected %0d actual %0d", $time, label, expv, actv);
      error_count++;
    end
  endtask

  // watch config writes and both channels
  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CH; c++) begin
        peak[c]      = '0;
        glow[c]      = '0;
        rise_mark[c] = '0;
        fall_mark[c] = '0;
      end
      rise_span     = '0;
      fall_span     = '0;
      hold_on_span  = '0;
      hold_off_span = '0;
      breath        = PH_RISE;
      hold_on_mark  = '0;
      hold_off_mark = '0;
      glow_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_RED:    peak[0] = cfg_data[LEVEL_W-1:0];
          REG_TARGET_GREEN:  peak[1] = cfg_data[LEVEL_W-1:0];
          REG_TARGET_BLUE:   peak[2] = cfg_data[LEVEL_W-1:0];
          REG_RISE_TIME:     rise_span = cfg_data[TOTAL_W-1:0];
          REG_FALL_TIME:     fall_span = cfg_data[TOTAL_W-1:0];
          REG_HOLD_ON_TIME:  hold_on_span = cfg_data[TOTAL_W-1:0];
          REG_HOLD_OFF_TIME: hold_off_span = cfg_data[TOTAL_W-1:0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        seen.red   = level_red;
        seen.green = level_green;
        seen.blue  = level_blue;
        seen.ph    = phase_t'(phase);
        if (glow_due.size() == 0) begin
          $display("%0t: result beat expected none actual r %0d g %0d b %0d phase %0d",
                   $time, seen.red, seen.green, seen.blue, seen.ph);
          error_count++;
        end else begin
          want = glow_due.pop_front();
          report_field("level_red", want.red, seen.red);
          report_field("level_green", want.green, seen.green);
          report_field("level_blue", want.blue, seen.blue);
          report_field("phase", want.ph, seen.ph);
        end
      end

      if (in_valid && in_ready) breathe(now);
    end
    results_owed <= glow_due.size();
  end

endmodule

// ----- tb/tb_rgb_breathing_fade_sequencer.sv -----
module tb_rgb_breathing_fade_sequencer;
  import rbfs_pkg::*;

  // an index past the register list, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int RANDOM_BEATS = 1450;
  localparam int DRAIN_CYCLES = 100;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [NOW_W-1:0]      now;
  logic                  out_valid;
  logic                  out_ready;
  logic [LEVEL_W-1:0]    level_red;
  logic [LEVEL_W-1:0]    level_green;
  logic [LEVEL_W-1:0]    level_blue;
  logic [1:0]            phase;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int               error_count;
  int               results_owed;
  logic             no_gaps;
  logic [NOW_W-1:0] wall_clock;
  int               beats_sent;

  // short ramp through all four phases, zero peak and a hold started at time zero
  logic [NOW_W-1:0] ramp_times [12] = '{
    32'd0, 32'd2, 32'd4, 32'd0, 32'd5, 32'd6, 32'd7, 32'd9, 32'd11, 32'd11, 32'd13,
    32'hFFFF_FFFF
  };
  // full-scale peaks with the longest spans, wide jumps and wrap
  logic [NOW_W-1:0] wide_times [6] = '{
    32'd0, 32'h0000_0102, 32'h0001_0000, 32'h8000_0000, 32'hFFFF_FFFE, 32'h0000_0001
  };
  // zero peaks below lit levels and zero spans
  logic [NOW_W-1:0] flat_times [5] = '{
    32'd1, 32'd2, 32'd3, 32'h5555_5555, 32'hAAAA_AAAA
  };

  rgb_breathing_fade_sequencer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .now        (now),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .level_red  (level_red),
    .level_green(level_green),
    .level_blue (level_blue),
    .phase      (phase),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rgb_breathing_fade_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .now         (now),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .level_red   (level_red),
    .level_green (level_green),
    .level_blue  (level_blue),
    .phase       (phase),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_span(input int zero_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_peak(input bit extreme);
    int roll;
    roll = $urandom_range(0, 99);
    if (extreme) return (roll < 50) ? 8'd0 : 8'd255;
    if (roll < 15) return 8'd0;
    if (roll < 85) return LEVEL_W'($urandom_range(1, 12));
    return LEVEL_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TOTAL_W-1:0] pick_span(input bit extreme);
    int roll;
    roll = $urandom_range(0, 99);
    if (extreme) return (roll < 50) ? 16'd0 : 16'hFFFF;
    if (roll < 10) return 16'd0;
    if (roll < 75) return TOTAL_W'($urandom_range(1, 40));
    if (roll < 90) return TOTAL_W'($urandom_range(0, 400));
    return TOTAL_W'($urandom_range(0, 65535));
  endfunction

  // one register write; the caller drops cfg_we after the last one
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // write every register, with junk in the unused high bits of the 8-bit ones
  task automatic load_registers(input logic [LEVEL_W-1:0] red, input logic [LEVEL_W-1:0] green,
                                input logic [LEVEL_W-1:0] blue, input logic [TOTAL_W-1:0] rise,
                                input logic [TOTAL_W-1:0] fall, input logic [TOTAL_W-1:0] hold_on,
                                input logic [TOTAL_W-1:0] hold_off);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    put_reg(REG_TARGET_RED, {junk, red});
    junk = 8'($urandom_range(0, 255));
    put_reg(REG_TARGET_GREEN, {junk, green});
    junk = 8'($urandom_range(0, 255));
    put_reg(REG_TARGET_BLUE, {junk, blue});
    put_reg(REG_RISE_TIME, rise);
    put_reg(REG_FALL_TIME, fall);
    put_reg(REG_HOLD_ON_TIME, hold_on);
    put_reg(REG_HOLD_OFF_TIME, hold_off);
    put_reg(REG_NONE, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
  endtask

  // one time beat, after a random gap; returns once accepted
  task automatic send_time(input logic [NOW_W-1:0] t);
    int gap;
    gap = no_gaps ? 0 : idle_span(65);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    now      <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait until every predicted result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // result side: ready runs broken by stalls
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!no_gaps) begin
        out_ready <= 1'b0;
        repeat (idle_span(0)) @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int               roll;
    int               stride;
    int               run;
    bit               extreme;
    logic [NOW_W-1:0] t;
    rst        = 1'b1;
    in_valid   = 1'b0;
    now        = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    no_gaps    = 1'b0;
    wall_clock = '0;
    beats_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    load_registers(8'd2, 8'd0, 8'd1, 16'd3, 16'd2, 16'd1, 16'd1);
    foreach (ramp_times[i]) send_time(ramp_times[i]);
    settle();
    load_registers(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    foreach (wide_times[i]) send_time(wide_times[i]);
    settle();
    load_registers(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    foreach (flat_times[i]) send_time(flat_times[i]);
    settle();

    // random settings, each followed by a run of mostly advancing time
    while (beats_sent < RANDOM_BEATS) begin
      extreme = ($urandom_range(0, 9) == 0);
      load_registers(pick_peak(extreme), pick_peak(extreme), pick_peak(extreme),
                     pick_span(extreme), pick_span(extreme), pick_span(extreme),
                     pick_span(extreme));
      no_gaps = ($urandom_range(0, 4) == 0);
      stride  = $urandom_range(2, 60);
      run     = $urandom_range(30, 110);
      repeat (run) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          wall_clock = wall_clock + $urandom_range(0, stride);
          t = wall_clock;
        end else if (roll < 86) begin
          wall_clock = wall_clock + $urandom;
          t = wall_clock;
        end else if (roll < 92) begin
          // stray time that breaks the sequence
          t = $urandom;
        end else if (roll < 96) begin
          t = '0;
        end else begin
          // just short of the wrap
          wall_clock = 32'hFFFF_FFFF - $urandom_range(0, 40);
          t = wall_clock;
        end
        send_time(t);
        beats_sent++;
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #60000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
